>>> hw/rtl/kvt_pkg.sv
// shared types and constants for the key/value table
// depends on nothing; imported by kvt_store and key_value_table
`default_nettype none

package kvt_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int KEY_W    = 31;
	localparam int VAL_W    = 31;
	localparam int CMD_W    = 3;
	localparam int STAT_W   = 3;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 3'd0,
		CMD_DUMP   = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_GET    = 3'd3,
		CMD_UPDATE = 3'd4,
		CMD_ERASE  = 3'd5
	} cmd_e;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_PRESENT   = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_FULL      = 3'd4
	} status_e;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	// write request into the slot memory
	typedef struct packed {
		logic   we;
		idx_t   addr;
		entry_t data;
	} wr_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/kvt_store.sv
// slot memory of the key/value table: one write port, one registered read port
// depends on kvt_pkg
`default_nettype none

module kvt_store (
	input  wire              clk,
	input  kvt_pkg::wr_req_t wr,
	input  wire              rd_en,
	input  kvt_pkg::idx_t    rd_addr,
	output kvt_pkg::entry_t  rd_data
);
	import kvt_pkg::*;

	entry_t mem_q [CAPACITY];
	entry_t rd_s1;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_s1 <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_s1;

endmodule

`default_nettype wire

>>> hw/rtl/key_value_table.sv
// key/value table: 64 slots, valid bits in flops, entries in kvt_store (uses kvt_pkg)
// clear goes straight to its final beat; other commands scan one slot per cycle
// while no dump stall holds the scan, then present a final beat
// one command at a time, each finishing before the next is accepted
// get, update, erase and a duplicate insert stop at the hit, dump stalls
// reset clears the valid bits at once (table empty); slot contents are left undefined
`default_nettype none

module key_value_table (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [63:0] s_axis_tdata,   // key [30:0], value [61:31], zero pad [63:62]
	input  wire  [2:0]  s_axis_tuser,   // cmd [2:0]
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [63:0] m_axis_tdata,   // out_key [30:0], out_value [61:31], zero [63:62]
	output logic [2:0]  m_axis_tuser,   // status [2:0]
	output logic        m_axis_tlast
);
	import kvt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	localparam idx_t LAST_IDX = idx_t'(CAPACITY - 1);

	state_t state_q;

	// command beat held for the whole scan
	cmd_e             cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;

	// valid bit per slot, cleared by reset
	logic [CAPACITY-1:0] valid_q;

	// read issue and the stage where read data comes back
	idx_t idx_q;
	logic iss_act_q;
	logic s1_vld_q;
	idx_t idx_s1;

	// scan findings
	logic             found_q;
	idx_t             found_idx_q;
	logic [VAL_W-1:0] found_val_q;
	logic             free_vld_q;
	idx_t             free_idx_q;

	// dump holds one entry back so the final one can carry tlast
	logic             pend_vld_q;
	logic [KEY_W-1:0] pend_key_q;
	logic [VAL_W-1:0] pend_val_q;

	// output register
	logic             m_vld_q;
	status_e          m_stat_q;
	logic [KEY_W-1:0] m_key_q;
	logic [VAL_W-1:0] m_val_q;
	logic             m_last_q;

	entry_t  rd_data;
	wr_req_t wr;

	logic    in_fire;
	logic    out_free;
	logic    s1_slot_v;
	logic    s1_match;
	logic    is_dump;
	logic    dump_push;
	logic    stall;
	logic    scan_stop;
	logic    rd_en;
	logic    fin_fire;
	cmd_e    in_cmd;
	logic    in_known;
	status_e fin_stat;
	logic [KEY_W-1:0] fin_key;
	logic [VAL_W-1:0] fin_val;

	kvt_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	// input side: a new command only once the previous one has finished
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign in_cmd        = cmd_e'(s_axis_tuser);
	// codes above erase do nothing and give no beat
	assign in_known      = (s_axis_tuser <= 3'(CMD_ERASE));

	assign out_free = !m_vld_q || m_axis_tready;

	// compare stage on the data read back for slot idx_s1
	assign s1_slot_v = valid_q[idx_s1];
	assign s1_match  = s1_vld_q && s1_slot_v && (rd_data.key == key_q);
	assign is_dump   = (cmd_q == CMD_DUMP);

	// dump sends the held entry when the next valid one turns up
	assign dump_push = (state_q == S_SCAN) && s1_vld_q && is_dump && s1_slot_v && pend_vld_q;
	// freeze issue and compare while that beat cannot leave
	assign stall     = dump_push && !out_free;

	// lookups stop at the hit (insert stops on a duplicate), all stop after the last slot
	assign scan_stop = (state_q == S_SCAN) && !stall && s1_vld_q &&
	                   ((s1_match && !is_dump) || (idx_s1 == LAST_IDX));
	assign rd_en     = (state_q == S_SCAN) && iss_act_q && !stall && !scan_stop;

	assign fin_fire  = (state_q == S_FIN) && out_free;

	// final beat of each command
	always_comb begin
		fin_stat = ST_OK;
		fin_key  = '0;
		fin_val  = '0;
		case (cmd_q)
			CMD_CLEAR: begin
				fin_stat = ST_OK;
			end
			CMD_DUMP: begin
				if (pend_vld_q) begin
					fin_key = pend_key_q;
					fin_val = pend_val_q;
				end else begin
					fin_stat = ST_EMPTY;
				end
			end
			CMD_INSERT: begin
				if (found_q) begin
					fin_stat = ST_PRESENT;
				end else if (!free_vld_q) begin
					fin_stat = ST_FULL;
				end
			end
			CMD_GET: begin
				if (found_q) begin
					fin_key = key_q;
					fin_val = found_val_q;
				end else begin
					fin_stat = ST_NOT_FOUND;
				end
			end
			CMD_UPDATE, CMD_ERASE: begin
				if (!found_q) begin
					fin_stat = ST_NOT_FOUND;
				end
			end
			default: begin
				fin_stat = ST_OK;
			end
		endcase
	end

	// memory write at the end of insert or update; no read is in flight then
	always_comb begin
		wr.we         = 1'b0;
		wr.addr       = found_idx_q;
		wr.data.key   = key_q;
		wr.data.value = value_q;
		if (fin_fire) begin
			if (cmd_q == CMD_UPDATE && found_q) begin
				wr.we = 1'b1;
			end else if (cmd_q == CMD_INSERT && !found_q && free_vld_q) begin
				wr.we   = 1'b1;
				wr.addr = free_idx_q;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			valid_q    <= '0;
			iss_act_q  <= 1'b0;
			s1_vld_q   <= 1'b0;
			found_q    <= 1'b0;
			free_vld_q <= 1'b0;
			pend_vld_q <= 1'b0;
			m_vld_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire && in_known) begin
						iss_act_q  <= 1'b1;
						found_q    <= 1'b0;
						free_vld_q <= 1'b0;
						pend_vld_q <= 1'b0;
						state_q    <= (in_cmd == CMD_CLEAR) ? S_FIN : S_SCAN;
					end
				end
				S_SCAN: begin
					if (!stall) begin
						s1_vld_q <= rd_en;
						if (rd_en && idx_q == LAST_IDX) begin
							iss_act_q <= 1'b0;
						end
						if (s1_match && !is_dump) begin
							found_q <= 1'b1;
						end
						if (s1_vld_q && !s1_slot_v && !free_vld_q) begin
							free_vld_q <= 1'b1;
						end
						if (s1_vld_q && s1_slot_v && is_dump) begin
							pend_vld_q <= 1'b1;
						end
						if (scan_stop) begin
							iss_act_q <= 1'b0;
							state_q   <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						case (cmd_q)
							CMD_CLEAR: begin
								valid_q <= '0;
							end
							CMD_INSERT: begin
								if (!found_q && free_vld_q) begin
									valid_q[free_idx_q] <= 1'b1;
								end
							end
							CMD_ERASE: begin
								if (found_q) begin
									valid_q[found_idx_q] <= 1'b0;
								end
							end
							default: begin
								valid_q <= valid_q;
							end
						endcase
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if ((dump_push && out_free) || fin_fire) begin
				m_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q   <= in_cmd;
			key_q   <= s_axis_tdata[KEY_W-1:0];
			value_q <= s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
			idx_q   <= '0;
		end else if (rd_en) begin
			idx_q <= idx_q + idx_t'(1);
		end

		if (state_q == S_SCAN && !stall) begin
			idx_s1 <= idx_q;
			if (s1_match && !is_dump) begin
				found_idx_q <= idx_s1;
				found_val_q <= rd_data.value;
			end
			if (s1_vld_q && !s1_slot_v && !free_vld_q) begin
				free_idx_q <= idx_s1;
			end
			if (s1_vld_q && s1_slot_v && is_dump) begin
				pend_key_q <= rd_data.key;
				pend_val_q <= rd_data.value;
			end
		end

		if (dump_push && out_free) begin
			m_stat_q <= ST_OK;
			m_key_q  <= pend_key_q;
			m_val_q  <= pend_val_q;
			m_last_q <= 1'b0;
		end else if (fin_fire) begin
			m_stat_q <= fin_stat;
			m_key_q  <= fin_key;
			m_val_q  <= fin_val;
			m_last_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tuser  = m_stat_q;
	assign m_axis_tdata  = {2'b00, m_val_q, m_key_q};
	assign m_axis_tlast  = m_last_q;

	// read data only comes back during a scan
	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld_q |-> (state_q == S_SCAN))
		else $error("read data stage live outside scan");

	// a stalled dump must keep its read data
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> $stable(rd_data) && $stable(idx_s1))
		else $error("read data lost during dump stall");

	// the slot memory is only written as a command finishes
	a_write_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> (state_q == S_FIN) && out_free)
		else $error("slot write outside command end");

	// held dump entry only exists for dump
	a_pend_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_vld_q && state_q != S_IDLE) |-> (cmd_q == CMD_DUMP))
		else $error("pending entry outside dump");

endmodule

`default_nettype wire
